FILE: rtl/complex_arithmetic_unit_defines.svh
// Assertion macros for the RTL file that checks itself.
`ifndef COMPLEX_ARITHMETIC_UNIT_DEFINES_SVH
`define COMPLEX_ARITHMETIC_UNIT_DEFINES_SVH

// A condition implies a consequence in the same cycle.
`define CAU_ASSERT_SAME(label, clk, rst, cond, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) else $error(msg);

// A condition implies a consequence in the following cycle.
`define CAU_ASSERT_NEXT(label, clk, rst, cond, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) else $error(msg);

`endif

FILE: rtl/cau_pkg.sv
package cau_pkg;

   // Defaults for the top level parameters.
   localparam int DATA_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF  = 16;

   // Fixed channel layout.
   localparam int FIELD_W     = 32;
   localparam int REQ_TDATA_W = 136;
   localparam int RSP_TDATA_W = 72;

   // Width of the sign-magnitude helper.
   localparam int SM_W = 64;

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2,
      OP_DIV = 2'd3
   } cau_op_type;

   typedef struct packed {
      logic             neg;
      logic [SM_W-1:0]  mag;
   } sm_type;

   // Control that travels with a transaction down the divider cells.
   typedef struct packed {
      logic valid;
      logic is_div;
      logic ok;
      logic neg_re;
      logic neg_im;
      logic ovf_re;
      logic ovf_im;
   } cau_ctl_type;

   // Sum of two sign-magnitude numbers.
   function automatic sm_type sm_add(input logic xn, input logic [SM_W-1:0] xm,
                                     input logic yn, input logic [SM_W-1:0] ym);
      sm_type r;
      if (xn == yn) begin
         r.neg = xn;
         r.mag = xm + ym;
      end else if (xm >= ym) begin
         r.neg = xn;
         r.mag = xm - ym;
      end else begin
         r.neg = yn;
         r.mag = ym - xm;
      end
      return r;
   endfunction

endpackage

FILE: rtl/cau_front.sv
module cau_front import cau_pkg::*; #(
   parameter int DATA_WIDTH = DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      enable,
   input  logic                      req_tvalid,
   input  logic [REQ_TDATA_W-1:0]    req_tdata,
   output cau_ctl_type               ctl_out,
   output logic [2*DATA_WIDTH-1:0]   den_out,
   output logic [2*DATA_WIDTH-1:0]   rem_re_out,
   output logic [2*DATA_WIDTH-1:0]   rem_im_out,
   output logic [DATA_WIDTH-1:0]     low_re_out,
   output logic [DATA_WIDTH-1:0]     low_im_out,
   output logic [DATA_WIDTH-1:0]     q_re_out,
   output logic [DATA_WIDTH-1:0]     q_im_out
);

   localparam int W  = DATA_WIDTH;
   localparam int PW = 2 * DATA_WIDTH;
   localparam int NW = 3 * DATA_WIDTH + FRAC_BITS;

   // Stage A: operands in sign-magnitude form (a_re, a_im, b_re, b_im).
   logic             a_valid_ff;
   cau_op_type       a_op_ff;
   logic             a_neg_ff [4];
   logic [W-1:0]     a_mag_ff [4];
   logic             a_neg_in [4];
   logic [W-1:0]     a_mag_in [4];

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         a_neg_in[k] = req_tdata[2 + FIELD_W*k + W - 1];
         a_mag_in[k] = a_neg_in[k] ? (W'(0) - req_tdata[2 + FIELD_W*k +: W])
                                   : req_tdata[2 + FIELD_W*k +: W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (enable) begin
         a_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         a_op_ff <= cau_op_type'(req_tdata[1:0]);
         for (int k = 0; k < 4; k++) begin
            a_neg_ff[k] <= a_neg_in[k];
            a_mag_ff[k] <= a_mag_in[k];
         end
      end
   end

   // Stage B: six products and the add or subtract sums.
   // Products: 0 ar*br, 1 ai*bi, 2 ai*br, 3 ar*bi, 4 br*br, 5 bi*bi.
   logic             b_valid_ff;
   cau_op_type       b_op_ff;
   logic [PW-1:0]    b_prod_ff [6];
   logic             b_psgn_ff [4];
   sm_type           b_sum_ff  [2];
   sm_type           b_sum_in  [2];
   logic             b_nbr;
   logic             b_nbi;

   always_comb begin
      b_nbr = a_neg_ff[2] ^ (a_op_ff == OP_SUB);
      b_nbi = a_neg_ff[3] ^ (a_op_ff == OP_SUB);
      b_sum_in[0] = sm_add(a_neg_ff[0], SM_W'(a_mag_ff[0]), b_nbr, SM_W'(a_mag_ff[2]));
      b_sum_in[1] = sm_add(a_neg_ff[1], SM_W'(a_mag_ff[1]), b_nbi, SM_W'(a_mag_ff[3]));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (enable) begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         b_op_ff      <= a_op_ff;
         b_prod_ff[0] <= PW'(a_mag_ff[0]) * PW'(a_mag_ff[2]);
         b_prod_ff[1] <= PW'(a_mag_ff[1]) * PW'(a_mag_ff[3]);
         b_prod_ff[2] <= PW'(a_mag_ff[1]) * PW'(a_mag_ff[2]);
         b_prod_ff[3] <= PW'(a_mag_ff[0]) * PW'(a_mag_ff[3]);
         b_prod_ff[4] <= PW'(a_mag_ff[2]) * PW'(a_mag_ff[2]);
         b_prod_ff[5] <= PW'(a_mag_ff[3]) * PW'(a_mag_ff[3]);
         b_psgn_ff[0] <= a_neg_ff[0] ^ a_neg_ff[2];
         b_psgn_ff[1] <= a_neg_ff[1] ^ a_neg_ff[3];
         b_psgn_ff[2] <= a_neg_ff[1] ^ a_neg_ff[2];
         b_psgn_ff[3] <= a_neg_ff[0] ^ a_neg_ff[3];
         b_sum_ff[0]  <= b_sum_in[0];
         b_sum_ff[1]  <= b_sum_in[1];
      end
   end

   // Stage C: combine the products and pick each lane's value by opcode.
   logic             c_valid_ff;
   cau_op_type       c_op_ff;
   logic             c_neg_ff [2];
   logic [PW-1:0]    c_num_ff [2];
   logic [PW-1:0]    c_den_ff;
   logic             c_ok_ff;
   sm_type           c_sel_in [2];
   logic [PW-1:0]    c_den_in;

   always_comb begin
      c_den_in = b_prod_ff[4] + b_prod_ff[5];
      case (b_op_ff)
         OP_MUL: begin
            c_sel_in[0] = sm_add(b_psgn_ff[0], SM_W'(b_prod_ff[0]),
                                 !b_psgn_ff[1], SM_W'(b_prod_ff[1]));
            c_sel_in[1] = sm_add(b_psgn_ff[2], SM_W'(b_prod_ff[2]),
                                 b_psgn_ff[3], SM_W'(b_prod_ff[3]));
         end
         OP_DIV: begin
            c_sel_in[0] = sm_add(b_psgn_ff[0], SM_W'(b_prod_ff[0]),
                                 b_psgn_ff[1], SM_W'(b_prod_ff[1]));
            c_sel_in[1] = sm_add(b_psgn_ff[2], SM_W'(b_prod_ff[2]),
                                 !b_psgn_ff[3], SM_W'(b_prod_ff[3]));
         end
         default: begin
            c_sel_in[0] = b_sum_ff[0];
            c_sel_in[1] = b_sum_ff[1];
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else if (enable) begin
         c_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         c_op_ff     <= b_op_ff;
         c_den_ff    <= c_den_in;
         c_ok_ff     <= !((b_op_ff == OP_DIV) && (c_den_in == '0));
         for (int k = 0; k < 2; k++) begin
            c_neg_ff[k] <= c_sel_in[k].neg;
            c_num_ff[k] <= c_sel_in[k].mag[PW-1:0];
         end
      end
   end

   // Stage D (combinational, registered by the first cell): set up the
   // long division or finish the scaling of the other operations.
   logic [NW-1:0]    d_num   [2];
   logic [NW-1:0]    d_dsh;
   logic [PW-1:0]    d_mag   [2];
   logic             d_ovf   [2];
   logic [PW-1:0]    d_rem   [2];
   logic [W-1:0]     d_low   [2];
   logic [W-1:0]     d_q     [2];
   logic             d_div;

   always_comb begin
      d_div = (c_op_ff == OP_DIV);
      d_dsh = NW'(c_den_ff) << W;
      for (int k = 0; k < 2; k++) begin
         d_num[k] = NW'(c_num_ff[k]) << FRAC_BITS;
         d_mag[k] = (c_op_ff == OP_MUL) ? (c_num_ff[k] >> FRAC_BITS) : c_num_ff[k];
         d_rem[k] = d_num[k][W +: PW];
         d_low[k] = d_num[k][W-1:0];
         if (d_div) begin
            // The quotient needs more than W bits exactly when num >= den << W.
            d_ovf[k] = (d_num[k] >= d_dsh);
            d_q[k]   = '0;
         end else begin
            d_ovf[k] = |d_mag[k][PW-1:W];
            d_q[k]   = d_mag[k][W-1:0];
         end
      end
   end

   assign ctl_out.valid  = c_valid_ff;
   assign ctl_out.is_div = d_div;
   assign ctl_out.ok     = c_ok_ff;
   assign ctl_out.neg_re = c_neg_ff[0];
   assign ctl_out.neg_im = c_neg_ff[1];
   assign ctl_out.ovf_re = d_ovf[0];
   assign ctl_out.ovf_im = d_ovf[1];
   assign den_out        = c_den_ff;
   assign rem_re_out     = d_rem[0];
   assign rem_im_out     = d_rem[1];
   assign low_re_out     = d_low[0];
   assign low_im_out     = d_low[1];
   assign q_re_out       = d_q[0];
   assign q_im_out       = d_q[1];

endmodule

FILE: rtl/cau_div_cell.sv
module cau_div_cell import cau_pkg::*; #(
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      enable,
   input  cau_ctl_type               ctl_up,
   input  logic [2*DATA_WIDTH-1:0]   den_up,
   input  logic [2*DATA_WIDTH-1:0]   rem_re_up,
   input  logic [2*DATA_WIDTH-1:0]   rem_im_up,
   input  logic [DATA_WIDTH-1:0]     low_re_up,
   input  logic [DATA_WIDTH-1:0]     low_im_up,
   input  logic [DATA_WIDTH-1:0]     q_re_up,
   input  logic [DATA_WIDTH-1:0]     q_im_up,
   output cau_ctl_type               ctl_out,
   output logic [2*DATA_WIDTH-1:0]   den_out,
   output logic [2*DATA_WIDTH-1:0]   rem_re_out,
   output logic [2*DATA_WIDTH-1:0]   rem_im_out,
   output logic [DATA_WIDTH-1:0]     low_re_out,
   output logic [DATA_WIDTH-1:0]     low_im_out,
   output logic [DATA_WIDTH-1:0]     q_re_out,
   output logic [DATA_WIDTH-1:0]     q_im_out
);

   localparam int W  = DATA_WIDTH;
   localparam int PW = 2 * DATA_WIDTH;

   cau_ctl_type     ctl_ff;
   logic [PW-1:0]   den_ff;
   logic [PW-1:0]   rem_re_ff, rem_im_ff, rem_re_in, rem_im_in;
   logic [W-1:0]    low_re_ff, low_im_ff, low_re_in, low_im_in;
   logic [W-1:0]    q_re_ff, q_im_ff, q_re_in, q_im_in;
   logic [PW:0]     try_re, try_im;
   logic            ge_re, ge_im;

   // One restoring division step per lane: bring down the next dividend bit.
   always_comb begin
      try_re    = {rem_re_up, low_re_up[W-1]};
      try_im    = {rem_im_up, low_im_up[W-1]};
      ge_re     = (try_re >= {1'b0, den_up});
      ge_im     = (try_im >= {1'b0, den_up});
      low_re_in = low_re_up << 1;
      low_im_in = low_im_up << 1;
      if (ctl_up.is_div) begin
         rem_re_in = ge_re ? PW'(try_re - {1'b0, den_up}) : try_re[PW-1:0];
         rem_im_in = ge_im ? PW'(try_im - {1'b0, den_up}) : try_im[PW-1:0];
         q_re_in   = {q_re_up[W-2:0], ge_re};
         q_im_in   = {q_im_up[W-2:0], ge_im};
      end else begin
         rem_re_in = rem_re_up;
         rem_im_in = rem_im_up;
         q_re_in   = q_re_up;
         q_im_in   = q_im_up;
      end
   end

   // Only the valid bit is reset; the rest moves whenever the pipeline does.
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.valid <= 1'b0;
      end else if (enable) begin
         ctl_ff.valid <= ctl_up.valid;
      end
      if (enable) begin
         ctl_ff.is_div <= ctl_up.is_div;
         ctl_ff.ok     <= ctl_up.ok;
         ctl_ff.neg_re <= ctl_up.neg_re;
         ctl_ff.neg_im <= ctl_up.neg_im;
         ctl_ff.ovf_re <= ctl_up.ovf_re;
         ctl_ff.ovf_im <= ctl_up.ovf_im;
         den_ff        <= den_up;
         rem_re_ff     <= rem_re_in;
         rem_im_ff     <= rem_im_in;
         low_re_ff     <= low_re_in;
         low_im_ff     <= low_im_in;
         q_re_ff       <= q_re_in;
         q_im_ff       <= q_im_in;
      end
   end

   assign ctl_out    = ctl_ff;
   assign den_out    = den_ff;
   assign rem_re_out = rem_re_ff;
   assign rem_im_out = rem_im_ff;
   assign low_re_out = low_re_ff;
   assign low_im_out = low_im_ff;
   assign q_re_out   = q_re_ff;
   assign q_im_out   = q_im_ff;

endmodule

FILE: rtl/complex_arithmetic_unit.sv
// Channel  Direction  Handshake                Payload
// req      in         req_tvalid / req_tready  op, a_re, a_im, b_re, b_im
// rsp      out        rsp_tvalid / rsp_tready  res_re, res_im, ok
//
// One transaction is accepted per cycle while no result is held. The path has
// three operand, product and combine stages, one divider cell per quotient
// bit, and the output register.
// Reset clears the valid bits of all stages; data registers are not reset.
// A held result stalls the whole pipeline; req_tready is low only then.
`include "complex_arithmetic_unit_defines.svh"

module complex_arithmetic_unit import cau_pkg::*; #(
   parameter int DATA_WIDTH = DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   // op[1:0], a_re[33:2], a_im[65:34], b_re[97:66], b_im[129:98], zero pad
   input  logic [REQ_TDATA_W-1:0]  req_tdata,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   // res_re[31:0], res_im[63:32], ok[64], zero pad
   output logic [RSP_TDATA_W-1:0]  rsp_tdata
);

   localparam int W  = DATA_WIDTH;
   localparam int PW = 2 * DATA_WIDTH;

   logic enable;

   // The pipeline moves unless a finished result is waiting.
   assign enable     = !rsp_tvalid || rsp_tready;
   assign req_tready = enable;

   cau_ctl_type    ctl_c    [W+1];
   logic [PW-1:0]  den_c    [W+1];
   logic [PW-1:0]  rem_re_c [W+1];
   logic [PW-1:0]  rem_im_c [W+1];
   logic [W-1:0]   low_re_c [W+1];
   logic [W-1:0]   low_im_c [W+1];
   logic [W-1:0]   q_re_c   [W+1];
   logic [W-1:0]   q_im_c   [W+1];

   cau_front #(
      .DATA_WIDTH (DATA_WIDTH),
      .FRAC_BITS  (FRAC_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .enable     (enable),
      .req_tvalid (req_tvalid),
      .req_tdata  (req_tdata),
      .ctl_out    (ctl_c[0]),
      .den_out    (den_c[0]),
      .rem_re_out (rem_re_c[0]),
      .rem_im_out (rem_im_c[0]),
      .low_re_out (low_re_c[0]),
      .low_im_out (low_im_c[0]),
      .q_re_out   (q_re_c[0]),
      .q_im_out   (q_im_c[0])
   );

   // One cell per quotient bit, most significant first.
   for (genvar i = 0; i < W; i++) begin : g_cell
      cau_div_cell #(
         .DATA_WIDTH (DATA_WIDTH)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .enable     (enable),
         .ctl_up     (ctl_c[i]),
         .den_up     (den_c[i]),
         .rem_re_up  (rem_re_c[i]),
         .rem_im_up  (rem_im_c[i]),
         .low_re_up  (low_re_c[i]),
         .low_im_up  (low_im_c[i]),
         .q_re_up    (q_re_c[i]),
         .q_im_up    (q_im_c[i]),
         .ctl_out    (ctl_c[i+1]),
         .den_out    (den_c[i+1]),
         .rem_re_out (rem_re_c[i+1]),
         .rem_im_out (rem_im_c[i+1]),
         .low_re_out (low_re_c[i+1]),
         .low_im_out (low_im_c[i+1]),
         .q_re_out   (q_re_c[i+1]),
         .q_im_out   (q_im_c[i+1])
      );
   end

   // Saturate each lane to the signed range and sign extend to the field.
   cau_ctl_type    fin;
   logic [W-1:0]   lim_re, lim_im, m_re, m_im, v_re, v_im;
   logic [FIELD_W-1:0] res_re, res_im;

   always_comb begin
      fin    = ctl_c[W];
      lim_re = fin.neg_re ? (W'(1) << (W-1)) : ((W'(1) << (W-1)) - W'(1));
      lim_im = fin.neg_im ? (W'(1) << (W-1)) : ((W'(1) << (W-1)) - W'(1));
      m_re   = (fin.ovf_re || (q_re_c[W] > lim_re)) ? lim_re : q_re_c[W];
      m_im   = (fin.ovf_im || (q_im_c[W] > lim_im)) ? lim_im : q_im_c[W];
      v_re   = fin.neg_re ? (W'(0) - m_re) : m_re;
      v_im   = fin.neg_im ? (W'(0) - m_im) : m_im;
      if (fin.ok) begin
         res_re = FIELD_W'($signed(v_re));
         res_im = FIELD_W'($signed(v_im));
      end else begin
         res_re = '0;
         res_im = '0;
      end
   end

   // Output register.
   logic                   rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_TDATA_W-1:0] rsp_tdata_ff, rsp_tdata_in;

   assign rsp_tvalid_in = fin.valid;
   assign rsp_tdata_in  = {(RSP_TDATA_W - 2*FIELD_W - 1)'(0), fin.ok, res_im, res_re};

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (enable) begin
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rsp_tdata_ff <= rsp_tdata_in;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   // Conditions watched by the checks below.
   logic rsp_stall, rsp_not_ok, rsp_res_zero, drain_idle;

   assign rsp_stall    = rsp_tvalid && !rsp_tready;
   assign rsp_not_ok   = rsp_tvalid && !rsp_tdata[2*FIELD_W];
   assign rsp_res_zero = (rsp_tdata[2*FIELD_W-1:0] == '0);
   assign drain_idle   = rsp_tready && !ctl_c[W].valid;

   // A waiting result blocks new transactions.
   `CAU_ASSERT_SAME(a_stall_req, clock, reset, rsp_stall, !req_tready, "req open in stall")
   // A cleared ok flag always comes with a zero result.
   `CAU_ASSERT_SAME(a_div0, clock, reset, rsp_not_ok, rsp_res_zero, "nonzero result, no ok")
   // A result taken with nothing in the last cell leaves the output empty.
   `CAU_ASSERT_NEXT(a_drain, clock, reset, drain_idle, !rsp_tvalid, "stray result")

endmodule
